// File: sv/gregorian_date_add_days_defines.svh
// assertion macros for the date adder checker
// no dependencies; taken in by the checker file only
`ifndef GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GDAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date adder check failed");

// next-cycle implication, disabled in reset
`define GDAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date adder check failed");

`endif

// File: sv/gdad_pkg.sv
// shared types, constants and month length table for the date adder
// no dependencies
`default_nettype none

package gdad_pkg;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [15:0] offset_days;
  } in_t;

  typedef struct packed {
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic [1:0]  status;
  } out_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [13:0] MAX_YEAR  = 14'd9999;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_LAST  = 5'd31;

  // floor(y / 100) = (y * 5243) >> 19 for any 14-bit y
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [6:0]  LAST_REM100 = 7'd99;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_CHECK,
    S_CARRY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic check;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic bad_date;
    logic fits;
    logic last_year;
  } sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: sv/gdad_ctrl.sv
// controller for the date adder: sequences load, year split, check and month carries
// depends on gdad_pkg
`default_nettype none

module gdad_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           out_stall,
  input  wire gdad_pkg::sts_t sts,
  output gdad_pkg::cmd_t      cmd,
  output logic                in_stall,
  output logic                out_valid
);

  gdad_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdad_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdad_pkg::S_IDLE:  if (in_valid) state_nxt = gdad_pkg::S_DIV;
      gdad_pkg::S_DIV:   state_nxt = gdad_pkg::S_REM;
      gdad_pkg::S_REM:   state_nxt = gdad_pkg::S_CHECK;
      gdad_pkg::S_CHECK: begin
        state_nxt = sts.bad_date ? gdad_pkg::S_DONE : gdad_pkg::S_CARRY;
      end
      gdad_pkg::S_CARRY: begin
        // saturation on the last december also ends the walk
        if (sts.fits || sts.last_year) state_nxt = gdad_pkg::S_DONE;
      end
      gdad_pkg::S_DONE:  if (!out_stall) state_nxt = gdad_pkg::S_IDLE;
      default:           state_nxt = gdad_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      gdad_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      gdad_pkg::S_DIV:   cmd.div   = 1'b1;
      gdad_pkg::S_REM:   cmd.rem   = 1'b1;
      gdad_pkg::S_CHECK: cmd.check = 1'b1;
      gdad_pkg::S_CARRY: cmd.step  = !sts.fits;
      gdad_pkg::S_DONE:  out_valid = 1'b1;
      default:           cmd       = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/gdad_dp.sv
// datapath for the date adder: date registers, leap tracking, month carry step
// depends on gdad_pkg
`default_nettype none

module gdad_dp (
  input  wire logic           clk,
  input  wire gdad_pkg::in_t  in_data,
  input  wire gdad_pkg::cmd_t cmd,
  output gdad_pkg::sts_t      sts,
  output gdad_pkg::out_t      result
);

  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [16:0] day_r, day_nxt;
  logic [15:0] off_r, off_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  q100_r, q100_nxt;
  logic [6:0]  rem100_r, rem100_nxt;
  logic [1:0]  cent_r, cent_nxt;

  logic [26:0] prod;
  logic [14:0] hund;
  logic [13:0] rem_full;
  logic        leap;
  logic [4:0]  mlen;

  assign prod     = {13'd0, year_r} * {14'd0, gdad_pkg::RECIP100};
  assign hund     = {7'd0, q100_r} * 15'd100;
  assign rem_full = year_r - hund[13:0];

  // leap: divisible by 4 and not by 100, or by 400 (century count divisible by 4)
  assign leap = ((year_r[1:0] == 2'd0) && (rem100_r != 7'd0)) ||
                ((rem100_r == 7'd0) && (cent_r == 2'd0));
  assign mlen = gdad_pkg::month_len(month_r, leap);

  assign sts.fits      = (day_r <= {12'd0, mlen});
  assign sts.bad_date  = (year_r == 14'd0) || (year_r > gdad_pkg::MAX_YEAR) ||
                         (day_r == 17'd0) || !sts.fits;
  assign sts.last_year = (month_r == gdad_pkg::MONTH_DEC) && (year_r == gdad_pkg::MAX_YEAR);

  always_comb begin
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    off_nxt    = off_r;
    status_nxt = status_r;
    q100_nxt   = q100_r;
    rem100_nxt = rem100_r;
    cent_nxt   = cent_r;
    if (cmd.load) begin
      year_nxt   = in_data.start_year;
      month_nxt  = in_data.start_month;
      day_nxt    = {12'd0, in_data.start_day};
      off_nxt    = in_data.offset_days;
      status_nxt = gdad_pkg::ST_OK;
    end else if (cmd.div) begin
      q100_nxt = prod[26:gdad_pkg::RECIP_SHIFT];
    end else if (cmd.rem) begin
      rem100_nxt = rem_full[6:0];
      cent_nxt   = q100_r[1:0];
    end else if (cmd.check) begin
      if (sts.bad_date) begin
        year_nxt   = '0;
        month_nxt  = '0;
        day_nxt    = '0;
        status_nxt = gdad_pkg::ST_BAD;
      end else begin
        day_nxt = day_r + {1'b0, off_r};
      end
    end else if (cmd.step) begin
      if (sts.last_year) begin
        month_nxt  = gdad_pkg::MONTH_DEC;
        day_nxt    = {12'd0, gdad_pkg::DAY_LAST};
        status_nxt = gdad_pkg::ST_OVF;
      end else begin
        day_nxt = day_r - {12'd0, mlen};
        if (month_r == gdad_pkg::MONTH_DEC) begin
          month_nxt = gdad_pkg::MONTH_JAN;
          year_nxt  = year_r + 14'd1;
          if (rem100_r == gdad_pkg::LAST_REM100) begin
            rem100_nxt = '0;
            cent_nxt   = cent_r + 2'd1;
          end else begin
            rem100_nxt = rem100_r + 7'd1;
          end
        end else begin
          month_nxt = month_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    off_r    <= off_nxt;
    status_r <= status_nxt;
    q100_r   <= q100_nxt;
    rem100_r <= rem100_nxt;
    cent_r   <= cent_nxt;
  end

  assign result.result_year  = year_r;
  assign result.result_month = month_r;
  assign result.result_day   = day_r[4:0];
  assign result.status       = status_r;

endmodule

`default_nettype wire

// File: sv/gregorian_date_add_days.sv
// top level of the gregorian date adder: controller plus datapath
// depends on gdad_pkg, gdad_ctrl, gdad_dp
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+------------------------------
//   input    | in_valid, in_stall, in_data    | gdad_pkg::in_t  (date, offset)
//   result   | out_valid, out_stall, out_data | gdad_pkg::out_t (date, status)
//
// one transaction at a time; once accepted, the year splits into century and remainder,
// the date is checked and the month carries (up to about 2155) are walked until the day
// fits; a saturating last carry ends the walk and an invalid date shows after the check
// in_stall is low only while idle, from the cycle after the result is taken
// the result holds while out_stall is high
// synchronous active-low reset returns the controller to idle
`default_nettype none

module gregorian_date_add_days (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire gdad_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output gdad_pkg::out_t      out_data
);

  // command and status between the sequencer and the datapath
  gdad_pkg::cmd_t cmd;
  gdad_pkg::sts_t sts;

  // controller: idle, year split, validity check, month carries, hold result
  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // datapath: date registers double as the output register
  gdad_dp u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .result  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/gdad_checker.sv
// port-level checker for the date adder, bound to the top level
// depends on gdad_pkg and gregorian_date_add_days_defines.svh
`default_nettype none

`include "gregorian_date_add_days_defines.svh"

module gdad_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire gdad_pkg::out_t out_data
);

  // a pending result holds still
  `GDAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // one transaction in flight: busy right after an accept
  `GDAD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // no input taken while a result is shown
  `GDAD_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, in_stall)

  // invalid date gives an all-zero date
  `GDAD_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid && (out_data.status == gdad_pkg::ST_BAD), (out_data.result_year == 14'd0) && (out_data.result_month == 4'd0) && (out_data.result_day == 5'd0))

  // overflow saturates to the last day of the last year
  `GDAD_ASSERT_NOW(a_ovf_sat, clk, rst_n, out_valid && (out_data.status == gdad_pkg::ST_OVF), (out_data.result_year == gdad_pkg::MAX_YEAR) && (out_data.result_month == gdad_pkg::MONTH_DEC) && (out_data.result_day == gdad_pkg::DAY_LAST))

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
